// File: hw/rtl/i2c_mrt_pkg.sv
package i2c_mrt_pkg;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ADDR  = 3'd2,
        PH_REG   = 3'd3,
        PH_DIR   = 3'd4,
        PH_XFER  = 3'd5
    } t_phase;

    // Bus actions handed to the byte-level controller
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RX_ACK  = 3'd3,
        ACT_RX_NACK = 3'd4,
        ACT_STOP    = 3'd5
    } t_action;

    // Request outcome
    typedef enum logic [1:0] {
        RS_OK    = 2'd0,
        RS_BUSY  = 2'd1,
        RS_COUNT = 2'd2
    } t_req_status;

    // Item kinds
    localparam logic REQ_TRANSFER = 1'b0;
    localparam logic REQ_EVENT    = 1'b1;

    // Controller status codes, bits 7..3
    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
    localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

    typedef struct packed {
        logic        req_type;
        logic [6:0]  device_addr;
        logic [7:0]  reg_addr;
        logic [3:0]  byte_count;
        logic        direction;
        logic [31:0] write_data;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        t_action     bus_action;
        logic [7:0]  tx_byte;
        t_req_status request_status;
        logic        busy_res;
        logic        done_res;
        logic [31:0] read_data;
    } t_out_item;

endpackage

// File: hw/rtl/i2c_mrt_core.sv
module i2c_mrt_core #(
    parameter int MAX_DATA_BYTES = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  i2c_mrt_pkg::t_in_item  i_item,
    output i2c_mrt_pkg::t_out_item o_res
);
    import i2c_mrt_pkg::*;

    localparam int CW  = $clog2(MAX_DATA_BYTES + 1);
    localparam int AW  = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam int EXW = 8 * MAX_DATA_BYTES + 32;
    localparam logic [3:0]    MAX_CNT = 4'(MAX_DATA_BYTES);
    localparam logic [CW-1:0] MAX_BD  = CW'(MAX_DATA_BYTES);

    // Transfer state
    t_phase        r_phase, n_phase;
    logic          r_is_write, n_is_write;
    logic [6:0]    r_addr, n_addr;
    logic [7:0]    r_reg, n_reg;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_bd, n_bd;
    logic [7:0]    r_store [MAX_DATA_BYTES];

    logic          load_wr;
    logic          rx_we;
    logic          do_restart;
    logic          do_stop;
    logic          all_done;
    logic [7:0]    st;
    logic [CW:0]   bd_p1;
    logic [CW:0]   bd_p2;
    logic [EXW-1:0] wd_ext;
    logic [EXW-1:0] rd_ext;
    logic [7:0]    rd_byte;

    assign wd_ext   = EXW'(i_item.write_data);
    assign st       = i_item.bus_status & STATUS_MASK;
    assign all_done = (r_bd >= r_total) || (r_bd >= MAX_BD);
    assign bd_p1    = {1'b0, r_bd} + (CW + 1)'(1);
    assign bd_p2    = {1'b0, r_bd} + (CW + 1)'(2);

    // Next state and result
    always_comb begin
        n_phase    = r_phase;
        n_is_write = r_is_write;
        n_addr     = r_addr;
        n_reg      = r_reg;
        n_total    = r_total;
        n_bd       = r_bd;
        load_wr    = 1'b0;
        rx_we      = 1'b0;
        do_restart = 1'b0;
        do_stop    = 1'b0;
        o_res      = '0;
        o_res.bus_action     = ACT_NONE;
        o_res.request_status = RS_OK;

        if (i_item.req_type == REQ_TRANSFER) begin
            if (r_phase != PH_IDLE) begin
                o_res.request_status = RS_BUSY;
            end else if (i_item.byte_count == 4'd0 || i_item.byte_count > MAX_CNT) begin
                o_res.request_status = RS_COUNT;
            end else begin
                n_addr     = i_item.device_addr;
                n_reg      = i_item.reg_addr;
                n_total    = CW'(i_item.byte_count);
                n_bd       = '0;
                n_is_write = i_item.direction;
                load_wr    = i_item.direction;
                n_phase    = PH_START;
                o_res.bus_action = ACT_START;
            end
        end else if (r_phase != PH_IDLE) begin
            if (st == ST_ARB_LOST) begin
                do_restart = 1'b1;
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (st != ST_START) begin
                            do_restart = 1'b1;
                        end else begin
                            o_res.bus_action = ACT_SEND;
                            o_res.tx_byte    = {r_addr, 1'b0};
                            n_phase          = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        if (st == ST_ADDR_W_NACK) begin
                            do_restart = 1'b1;
                        end else begin
                            o_res.bus_action = ACT_SEND;
                            o_res.tx_byte    = r_reg;
                            n_phase          = PH_REG;
                        end
                    end
                    PH_REG: begin
                        if (st != ST_DATA_TX_ACK) begin
                            do_restart = 1'b1;
                        end else begin
                            o_res.bus_action = ACT_START;
                            n_phase          = PH_DIR;
                        end
                    end
                    PH_DIR: begin
                        if (st != ST_START && st != ST_RESTART) begin
                            do_restart = 1'b1;
                        end else begin
                            o_res.bus_action = ACT_SEND;
                            o_res.tx_byte    = {r_addr, ~r_is_write};
                            n_phase          = PH_XFER;
                        end
                    end
                    PH_XFER: begin
                        if (r_is_write) begin
                            // write data bytes
                            if (st == ST_ADDR_W_ACK || st == ST_DATA_TX_ACK) begin
                                if (all_done) begin
                                    do_stop = 1'b1;
                                end else begin
                                    o_res.bus_action = ACT_SEND;
                                    o_res.tx_byte    = r_store[r_bd[AW-1:0]];
                                    n_bd             = bd_p1[CW-1:0];
                                end
                            end else if (st == ST_DATA_TX_NACK) begin
                                do_stop = 1'b1;
                            end else begin
                                do_restart = 1'b1;
                            end
                        end else begin
                            // read data bytes
                            if (st == ST_ADDR_R_ACK) begin
                                o_res.bus_action = (r_total > CW'(1)) ? ACT_RX_ACK
                                                                      : ACT_RX_NACK;
                            end else if (st == ST_DATA_RX_ACK) begin
                                if (all_done) begin
                                    do_restart = 1'b1;
                                end else begin
                                    rx_we = 1'b1;
                                    n_bd  = bd_p1[CW-1:0];
                                    o_res.bus_action = (bd_p2 >= {1'b0, r_total})
                                                       ? ACT_RX_NACK : ACT_RX_ACK;
                                end
                            end else if (st == ST_DATA_RX_NACK) begin
                                if (!all_done) begin
                                    rx_we = 1'b1;
                                    n_bd  = bd_p1[CW-1:0];
                                end
                                do_stop = 1'b1;
                            end else begin
                                do_restart = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        if (do_restart) begin
            o_res.bus_action = ACT_START;
            n_phase          = PH_START;
            n_bd             = '0;
        end
        if (do_stop) begin
            o_res.bus_action = ACT_STOP;
            n_phase          = PH_IDLE;
            o_res.done_res   = 1'b1;
        end

        // Gather received bytes on the closing item of a read
        rd_ext  = '0;
        rd_byte = '0;
        if (do_stop && !r_is_write) begin
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                rd_byte = (rx_we && r_bd == CW'(i)) ? i_item.rx_byte : r_store[i];
                if ({1'b0, n_bd} > (CW + 1)'(i)) begin
                    rd_ext[8*i +: 8] = rd_byte;
                end
            end
        end
        o_res.read_data = rd_ext[31:0];
        o_res.busy_res  = (n_phase != PH_IDLE);
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_is_write <= 1'b0;
            r_addr     <= '0;
            r_reg      <= '0;
            r_total    <= '0;
            r_bd       <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_is_write <= n_is_write;
            r_addr     <= n_addr;
            r_reg      <= n_reg;
            r_total    <= n_total;
            r_bd       <= n_bd;
        end
    end

    // Data byte store: loaded by a write request, filled by received bytes
    always_ff @(posedge i_clk) begin
        if (i_fire && load_wr) begin
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                if (i < int'(i_item.byte_count)) begin
                    r_store[i] <= wd_ext[8*i +: 8];
                end
            end
        end else if (i_fire && rx_we) begin
            r_store[r_bd[AW-1:0]] <= i_item.rx_byte;
        end
    end

endmodule

// File: hw/rtl/i2c_master_register_transfer_top.sv
// A request waits in the input register; its result is then registered in the
// result register that drives m_axis. Throughput: one request per cycle while
// m_axis_tready holds high; the input register and the result register let a new
// request in while a finished result still waits on m_axis_tready.
// Reset: synchronous, active low; the sequencer returns to idle, both registers
// empty. The data byte store is not cleared.
module i2c_master_register_transfer_top #(
    parameter int MAX_DATA_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // device_addr[6:0], reg_addr[14:7], byte_count[18:15], direction[19],
    // write_data[51:20], bus_status[59:52], rx_byte[67:60], zero[71:68]
    input  logic [71:0] s_axis_tdata,
    // req_type[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bus_action[2:0], tx_byte[10:3], request_status[12:11], busy_res[13],
    // done_res[14], read_data[46:15], zero[47]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);
    import i2c_mrt_pkg::*;

    t_in_item  r_in, n_in;
    logic      r_in_valid;
    t_out_item r_out, w_res;
    logic      r_out_valid;
    logic      w_out_free;
    logic      w_fire;

    // Handshake
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_fire;

    // Unpack request
    always_comb begin
        n_in.req_type    = s_axis_tuser;
        n_in.device_addr = s_axis_tdata[6:0];
        n_in.reg_addr    = s_axis_tdata[14:7];
        n_in.byte_count  = s_axis_tdata[18:15];
        n_in.direction   = s_axis_tdata[19];
        n_in.write_data  = s_axis_tdata[51:20];
        n_in.bus_status  = s_axis_tdata[59:52];
        n_in.rx_byte     = s_axis_tdata[67:60];
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= n_in;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    i2c_mrt_core #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.read_data, r_out.done_res, r_out.busy_res,
                            r_out.request_status, r_out.tx_byte, r_out.bus_action};

    // Checks
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.done_res && r_out.busy_res))
        else $error("transfer reported done while still busy");

    a_refused_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.request_status != RS_OK |-> r_out.bus_action == ACT_NONE)
        else $error("refused request produced a bus action");

    a_tx_only_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bus_action != ACT_SEND |-> r_out.tx_byte == 8'h00)
        else $error("tx byte driven without a send action");

    a_rdata_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.done_res |-> r_out.read_data == 32'h0)
        else $error("read data shown before the transfer finished");

endmodule

// File: sim/i2c_mrt_checker.sv
`timescale 1ns / 1ps

// Watches both stream ports of the register-transfer sequencer, keeps its own
// copy of the sequencer state and compares every result with the oldest
// outstanding prediction.
module i2c_mrt_checker #(
    parameter int MAX_DATA_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // device_addr[6:0], reg_addr[14:7], byte_count[18:15], direction[19],
    // write_data[51:20], bus_status[59:52], rx_byte[67:60], zero[71:68]
    input  logic [71:0] i_s_tdata,
    // req_type[0]
    input  logic        i_s_tuser,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // bus_action[2:0], tx_byte[10:3], request_status[12:11], busy_res[13],
    // done_res[14], read_data[46:15], zero[47]
    input  logic [47:0] i_m_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    output int          o_errors,
    output int          o_pending
);
    import i2c_mrt_pkg::*;

    // Shadow sequencer state
    t_phase     seq_phase;
    logic       seq_write;
    logic [6:0] seq_dev;
    logic [7:0] seq_reg;
    logic [2:0] seq_total;
    logic [2:0] seq_done;
    logic [7:0] seq_bytes [MAX_DATA_BYTES];

    t_out_item  awaited_actions [$];
    int         result_idx;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                   result_idx, name, got, want));
        end
    endtask

    // Restart from the start condition; byte progress is dropped
    function automatic void seq_restart(inout t_out_item r);
        r.bus_action = ACT_START;
        seq_phase    = PH_START;
        seq_done     = '0;
    endfunction

    function automatic void seq_stop(inout t_out_item r);
        r.bus_action = ACT_STOP;
        r.done_res   = 1'b1;
        seq_phase    = PH_IDLE;
    endfunction

    function automatic void seq_send(inout t_out_item r, input logic [7:0] b);
        r.bus_action = ACT_SEND;
        r.tx_byte    = b;
    endfunction

    // Bus action and status caused by one request
    function automatic t_out_item bus_response(input t_in_item it);
        t_out_item  r;
        logic [7:0] st;
        r = '0;
        r.bus_action     = ACT_NONE;
        r.request_status = RS_OK;
        if (it.req_type == REQ_TRANSFER) begin
            if (seq_phase != PH_IDLE) begin
                r.request_status = RS_BUSY;
            end else if (it.byte_count == 4'd0 || it.byte_count > MAX_DATA_BYTES) begin
                r.request_status = RS_COUNT;
            end else begin
                seq_dev   = it.device_addr;
                seq_reg   = it.reg_addr;
                seq_total = 3'(it.byte_count);
                seq_done  = '0;
                seq_write = it.direction;
                if (seq_write) begin
                    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                        if (i < it.byte_count) seq_bytes[i] = it.write_data[8*i +: 8];
                    end
                end
                seq_phase    = PH_START;
                r.bus_action = ACT_START;
            end
        end else if (seq_phase != PH_IDLE) begin
            st = it.bus_status & STATUS_MASK;
            if (st == ST_ARB_LOST) begin
                seq_restart(r);
            end else begin
                case (seq_phase)
                    PH_START: begin
                        if (st != ST_START) begin
                            seq_restart(r);
                        end else begin
                            seq_send(r, {seq_dev, 1'b0});
                            seq_phase = PH_ADDR;
                        end
                    end
                    // only an address NACK is refused here
                    PH_ADDR: begin
                        if (st == ST_ADDR_W_NACK) begin
                            seq_restart(r);
                        end else begin
                            seq_send(r, seq_reg);
                            seq_phase = PH_REG;
                        end
                    end
                    PH_REG: begin
                        if (st != ST_DATA_TX_ACK) begin
                            seq_restart(r);
                        end else begin
                            r.bus_action = ACT_START;
                            seq_phase    = PH_DIR;
                        end
                    end
                    PH_DIR: begin
                        if (st != ST_START && st != ST_RESTART) begin
                            seq_restart(r);
                        end else begin
                            seq_send(r, {seq_dev, ~seq_write});
                            seq_phase = PH_XFER;
                        end
                    end
                    PH_XFER: begin
                        if (seq_write) begin
                            if (st == ST_ADDR_W_ACK || st == ST_DATA_TX_ACK) begin
                                if (seq_done >= seq_total) begin
                                    seq_stop(r);
                                end else begin
                                    seq_send(r, seq_bytes[seq_done]);
                                    seq_done++;
                                end
                            end else if (st == ST_DATA_TX_NACK) begin
                                seq_stop(r);
                            end else begin
                                seq_restart(r);
                            end
                        end else if (st == ST_ADDR_R_ACK) begin
                            r.bus_action = (seq_total > 1) ? ACT_RX_ACK : ACT_RX_NACK;
                        end else if (st == ST_DATA_RX_ACK) begin
                            // one ACK too many means the count is already full
                            if (seq_done >= seq_total) begin
                                seq_restart(r);
                            end else begin
                                seq_bytes[seq_done] = it.rx_byte;
                                seq_done++;
                                r.bus_action = (seq_done + 1 >= seq_total) ? ACT_RX_NACK
                                                                           : ACT_RX_ACK;
                            end
                        end else if (st == ST_DATA_RX_NACK) begin
                            if (seq_done < seq_total) begin
                                seq_bytes[seq_done] = it.rx_byte;
                                seq_done++;
                            end
                            seq_stop(r);
                        end else begin
                            seq_restart(r);
                        end
                    end
                    default: begin
                        seq_phase = PH_IDLE;
                    end
                endcase
            end
        end
        // received bytes show only on the stop of a read
        if (r.done_res && !seq_write) begin
            for (int i = 0; i < MAX_DATA_BYTES && i < 4; i++) begin
                if (i < seq_done) r.read_data[8*i +: 8] = seq_bytes[i];
            end
        end
        r.busy_res = (seq_phase != PH_IDLE);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_in_item  req;
        t_out_item want;
        if (!i_rst_n) begin
            seq_phase = PH_IDLE;
            seq_write = 1'b0;
            seq_dev   = '0;
            seq_reg   = '0;
            seq_total = '0;
            seq_done  = '0;
            awaited_actions.delete();
        end else begin
            // results first: one leaving now always belongs to an older request
            if (i_m_tvalid && i_m_tready) begin
                result_idx++;
                if (awaited_actions.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing outstanding",
                                           result_idx));
                end else begin
                    want = awaited_actions.pop_front();
                    check_field("bus_action",     i_m_tdata[2:0],   want.bus_action);
                    check_field("tx_byte",        i_m_tdata[10:3],  want.tx_byte);
                    check_field("request_status", i_m_tdata[12:11], want.request_status);
                    check_field("busy_res",       i_m_tdata[13],    want.busy_res);
                    check_field("done_res",       i_m_tdata[14],    want.done_res);
                    check_field("read_data",      i_m_tdata[46:15], want.read_data);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                req.req_type    = i_s_tuser;
                req.device_addr = i_s_tdata[6:0];
                req.reg_addr    = i_s_tdata[14:7];
                req.byte_count  = i_s_tdata[18:15];
                req.direction   = i_s_tdata[19];
                req.write_data  = i_s_tdata[51:20];
                req.bus_status  = i_s_tdata[59:52];
                req.rx_byte     = i_s_tdata[67:60];
                awaited_actions.push_back(bus_response(req));
            end
        end
        o_pending = awaited_actions.size();
    end

endmodule

// File: sim/tb_i2c_master_register_transfer_top.sv
`timescale 1ns / 1ps

module tb_i2c_master_register_transfer_top;
    import i2c_mrt_pkg::*;

    localparam int N_ITEMS     = 1050;
    localparam int HOLD_START  = 200;
    localparam int HOLD_CYCLES = 250;

    logic        clk;
    logic        rst_n;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    int          n_errors;
    int          n_pending;
    int          n_items;
    int          burst_left;

    i2c_master_register_transfer_top #(
        .MAX_DATA_BYTES(4)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    i2c_mrt_checker #(
        .MAX_DATA_BYTES(4)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_errors   (n_errors),
        .o_pending  (n_pending)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial begin
        #2_000_000;
        $display("tb_i2c_master_register_transfer_top failed");
        $finish;
    end

    // Receiver: stall pattern is picked at random and changes over the run, plus one long hold-off
    initial begin : rx_stall
        int cyc;
        int mode;
        m_axis_tready = 1'b0;
        cyc  = 0;
        mode = 0;
        forever begin
            @(posedge clk);
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (cyc % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
            cyc++;
        end
    end

    function automatic logic [7:0] rand_code();
        return {5'($urandom_range(0, 31)), 3'b000};
    endfunction

    // Offer one request; bursts of back-to-back requests with random gaps
    task automatic push_item(input t_in_item it);
        int   gap;
        logic rdy;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {4'b0000, it.rx_byte, it.bus_status, it.write_data, it.direction,
                          it.byte_count, it.reg_addr, it.device_addr};
        s_axis_tuser  <= it.req_type;
        s_axis_tvalid <= 1'b1;
        // ready is settled at the falling edge before the accepting edge
        do begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic send_req(input logic dir, input logic [6:0] dev, input logic [7:0] reg_idx,
                            input logic [3:0] cnt, input logic [31:0] wdata);
        t_in_item    it;
        logic [95:0] noise;
        noise          = {$urandom, $urandom, $urandom};
        it             = noise[68:0];
        it.req_type    = REQ_TRANSFER;
        it.device_addr = dev;
        it.reg_addr    = reg_idx;
        it.byte_count  = cnt;
        it.direction   = dir;
        it.write_data  = wdata;
        n_items++;
        push_item(it);
    endtask

    // Bus status event; low status bits and unused fields are random
    task automatic send_evt(input logic [7:0] code, input logic counts);
        t_in_item    it;
        logic [95:0] noise;
        noise         = {$urandom, $urandom, $urandom};
        it            = noise[68:0];
        it.req_type   = REQ_EVENT;
        it.bus_status = code | 8'($urandom_range(0, 7));
        if (counts) n_items++;
        push_item(it);
    endtask

    initial begin : stimulus
        t_phase     gen_phase;
        logic       dir;
        logic [3:0] cnt;
        int         sent;
        logic       rd_started;
        logic       restarted;
        int         pick;
        logic [7:0] code;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        n_items       = 0;
        burst_left    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // event while idle, refused counts
        send_evt(ST_START, 1'b0);
        send_req(1'b1, 7'h00, 8'h00, 4'd0, 32'h0000_0000);
        send_req(1'b1, 7'h7F, 8'hFF, 4'd15, 32'hFFFF_FFFF);
        send_req(1'b0, 7'h55, 8'hAA, 4'd5, 32'h0000_0000);

        // four-byte write with repeated start and a request while busy
        send_req(1'b1, 7'h7F, 8'hFF, 4'd4, 32'hFFFF_FFFF);
        send_evt(ST_START, 1'b1);
        send_evt(ST_ADDR_W_ACK, 1'b1);
        send_req(1'b0, 7'h01, 8'h01, 4'd1, 32'h0000_0000);
        send_evt(ST_DATA_TX_ACK, 1'b1);
        send_evt(ST_RESTART, 1'b1);
        send_evt(ST_ADDR_W_ACK, 1'b1);
        repeat (4) send_evt(ST_DATA_TX_ACK, 1'b1);

        // one-byte read interrupted by arbitration loss
        send_req(1'b0, 7'h00, 8'h00, 4'd1, 32'h0000_0000);
        send_evt(ST_ARB_LOST, 1'b1);
        send_evt(ST_START, 1'b1);
        send_evt(ST_ADDR_W_ACK, 1'b1);
        send_evt(ST_DATA_TX_ACK, 1'b1);
        send_evt(ST_START, 1'b1);
        send_evt(ST_ADDR_R_ACK, 1'b1);
        send_evt(ST_DATA_RX_NACK, 1'b1);

        // random transfers, mostly well formed, with broken steps and noise
        while (n_items < N_ITEMS) begin
            if ($urandom_range(0, 7) == 0) send_evt(rand_code(), 1'b0);
            if ($urandom_range(0, 7) == 0) begin
                pick = $urandom_range(0, 11);
                send_req(1'($urandom), 7'($urandom), 8'($urandom),
                         (pick == 0) ? 4'd0 : 4'(pick + 4), $urandom);
            end
            dir = 1'($urandom_range(0, 1));
            cnt = 4'($urandom_range(1, 4));
            send_req(dir, 7'($urandom), 8'($urandom), cnt, $urandom);
            gen_phase  = PH_START;
            sent       = 0;
            rd_started = 1'b0;
            while (gen_phase != PH_IDLE) begin
                restarted = 1'b0;
                pick = $urandom_range(0, 31);
                if (pick == 0) begin
                    send_req(1'($urandom), 7'($urandom), 8'($urandom), 4'($urandom), $urandom);
                end else if (pick == 1) begin
                    send_evt(ST_ARB_LOST, 1'b1);
                    restarted = 1'b1;
                end else begin
                    pick = $urandom_range(0, 15);
                    case (gen_phase)
                        PH_START: begin
                            if (pick == 0) begin
                                do code = rand_code(); while (code == ST_START);
                                send_evt(code, 1'b1);
                                restarted = 1'b1;
                            end else begin
                                send_evt(ST_START, 1'b1);
                                gen_phase = PH_ADDR;
                            end
                        end
                        PH_ADDR: begin
                            if (pick == 0) begin
                                send_evt(ST_ADDR_W_NACK, 1'b1);
                                restarted = 1'b1;
                            end else begin
                                // any status but a NACK or an arbitration loss moves on to the register
                                code = ST_ADDR_W_ACK;
                                if (pick < 4) begin
                                    do code = rand_code();
                                    while (code == ST_ADDR_W_NACK || code == ST_ARB_LOST);
                                end
                                send_evt(code, 1'b1);
                                gen_phase = PH_REG;
                            end
                        end
                        PH_REG: begin
                            if (pick == 0) begin
                                do code = rand_code(); while (code == ST_DATA_TX_ACK);
                                send_evt(code, 1'b1);
                                restarted = 1'b1;
                            end else begin
                                send_evt(ST_DATA_TX_ACK, 1'b1);
                                gen_phase = PH_DIR;
                            end
                        end
                        PH_DIR: begin
                            if (pick == 0) begin
                                do code = rand_code();
                                while (code == ST_START || code == ST_RESTART);
                                send_evt(code, 1'b1);
                                restarted = 1'b1;
                            end else begin
                                send_evt(pick[0] ? ST_START : ST_RESTART, 1'b1);
                                gen_phase = PH_XFER;
                            end
                        end
                        PH_XFER: begin
                            if (dir) begin
                                if (pick == 0) begin
                                    do code = rand_code();
                                    while (code == ST_ADDR_W_ACK || code == ST_DATA_TX_ACK ||
                                           code == ST_DATA_TX_NACK);
                                    send_evt(code, 1'b1);
                                    restarted = 1'b1;
                                end else if (pick == 1) begin
                                    // device NACK ends the write early
                                    send_evt(ST_DATA_TX_NACK, 1'b1);
                                    gen_phase = PH_IDLE;
                                end else begin
                                    send_evt((pick < 4) ? ST_ADDR_W_ACK : ST_DATA_TX_ACK, 1'b1);
                                    if (sent >= cnt) gen_phase = PH_IDLE;
                                    else sent++;
                                end
                            end else begin
                                if (pick == 0) begin
                                    do code = rand_code();
                                    while (code == ST_ADDR_R_ACK || code == ST_DATA_RX_ACK ||
                                           code == ST_DATA_RX_NACK);
                                    send_evt(code, 1'b1);
                                    restarted = 1'b1;
                                end else if (pick == 1 || !rd_started) begin
                                    send_evt(ST_ADDR_R_ACK, 1'b1);
                                    rd_started = 1'b1;
                                end else if (pick == 2) begin
                                    send_evt(ST_DATA_RX_NACK, 1'b1);
                                    gen_phase = PH_IDLE;
                                end else if (pick == 3 || sent < cnt - 1) begin
                                    // an extra ACK past the count forces a restart
                                    send_evt(ST_DATA_RX_ACK, 1'b1);
                                    if (sent >= cnt) restarted = 1'b1;
                                    else sent++;
                                end else begin
                                    send_evt(ST_DATA_RX_NACK, 1'b1);
                                    gen_phase = PH_IDLE;
                                end
                            end
                        end
                        default: begin
                            gen_phase = PH_IDLE;
                        end
                    endcase
                end
                if (restarted) begin
                    gen_phase  = PH_START;
                    sent       = 0;
                    rd_started = 1'b0;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then keep watching for stray results
        do @(negedge clk); while (n_pending != 0);
        repeat (10) @(negedge clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("tb_i2c_master_register_transfer_top passed");
        end else begin
            $display("tb_i2c_master_register_transfer_top failed");
        end
        $finish;
    end

endmodule
